// ===== src/rlen_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the route length block
// no dependencies
package rlen_pkg;

  // widest point index the block is built for (up to 1024 points)
  localparam int IDX_MAX_W  = 10;
  // compare width for indices and facility rows, one above the widest index
  localparam int CMP_W      = IDX_MAX_W + 1;
  // widest stored distance
  localparam int DIST_MAX_W = 32;
  // running total width
  localparam int TOTAL_W    = 32;
  // field widths fixed by the stream format
  localparam int PT_W       = 7;
  localparam int FAC_W      = 3;
  localparam int DIN_W      = 24;

  // command codes carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_ROUTE = 1'b1;

  // one classified operation handed from front to back
  typedef struct packed {
    logic                  is_route;
    logic                  first;
    logic                  last;
    logic                  leg_ok;   // leg (or write) address in range
    logic                  ret_ok;   // return leg address in range
    logic [IDX_MAX_W-1:0]  leg_row;  // write row, or leg source row
    logic [IDX_MAX_W-1:0]  leg_col;  // write column, or current customer
    logic [IDX_MAX_W-1:0]  ret_row;  // facility row for the return leg
    logic [DIST_MAX_W-1:0] wdata;
  } rlen_op_t;

endpackage

// ===== src/rlen_front.sv =====
`timescale 1ns / 1ps
// front end: accepts words, tracks the previous customer and builds table addresses
// depends on rlen_pkg
module rlen_front #(
  parameter int MAX_POINTS = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rlen_pkg::PT_W-1:0]      customer_count,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [rlen_pkg::PT_W-1:0]      row,
  input  logic [rlen_pkg::PT_W-1:0]      col,
  input  logic [rlen_pkg::DIN_W-1:0]     distance,
  input  logic [rlen_pkg::PT_W-1:0]      customer,
  input  logic [rlen_pkg::FAC_W-1:0]     facility,
  input  logic                           first_stop,
  input  logic                           last_stop,
  output logic                           op_valid,
  input  logic                           op_ready,
  output rlen_pkg::rlen_op_t             op
);

  localparam logic [rlen_pkg::CMP_W-1:0] LIMIT = rlen_pkg::CMP_W'(MAX_POINTS);

  logic [rlen_pkg::PT_W-1:0]  prev_cust;
  logic [rlen_pkg::PT_W-1:0]  prev_cust_next;
  logic [rlen_pkg::CMP_W-1:0] frow;
  logic [rlen_pkg::CMP_W-1:0] row_x;
  logic [rlen_pkg::CMP_W-1:0] col_x;
  logic [rlen_pkg::CMP_W-1:0] cust_x;
  logic [rlen_pkg::CMP_W-1:0] leg_row_x;
  logic                       route;
  logic                       accept;

  assign in_ready = op_ready;
  assign op_valid = in_valid;
  assign accept   = in_valid && op_ready;
  assign route    = (command == rlen_pkg::CMD_ROUTE);

  always_comb begin
    frow      = rlen_pkg::CMP_W'(customer_count) + rlen_pkg::CMP_W'(facility);
    row_x     = rlen_pkg::CMP_W'(row);
    col_x     = rlen_pkg::CMP_W'(col);
    cust_x    = rlen_pkg::CMP_W'(customer);
    leg_row_x = first_stop ? frow : rlen_pkg::CMP_W'(prev_cust);

    op          = '0;
    op.is_route = route;
    op.first    = first_stop;
    op.last     = last_stop;
    op.wdata    = rlen_pkg::DIST_MAX_W'(distance);
    op.ret_row  = frow[rlen_pkg::IDX_MAX_W-1:0];
    op.ret_ok   = (frow < LIMIT) && (cust_x < LIMIT);
    if (route) begin
      op.leg_row = leg_row_x[rlen_pkg::IDX_MAX_W-1:0];
      op.leg_col = cust_x[rlen_pkg::IDX_MAX_W-1:0];
      op.leg_ok  = (leg_row_x < LIMIT) && (cust_x < LIMIT);
    end else begin
      op.leg_row = row_x[rlen_pkg::IDX_MAX_W-1:0];
      op.leg_col = col_x[rlen_pkg::IDX_MAX_W-1:0];
      op.leg_ok  = (row_x < LIMIT) && (col_x < LIMIT);
    end

    prev_cust_next = prev_cust;
    if (accept && route) begin
      prev_cust_next = customer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cust <= '0;
    end else begin
      prev_cust <= prev_cust_next;
    end
  end

endmodule

// ===== src/rlen_queue.sv =====
`timescale 1ns / 1ps
// short operation queue between front and back
// depends on rlen_pkg
module rlen_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlen_pkg::rlen_op_t in_op,
  output logic               out_valid,
  input  logic               out_ready,
  output rlen_pkg::rlen_op_t out_op
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  rlen_pkg::rlen_op_t slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != (PTR_W + 1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_op    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/rlen_back.sv =====
`timescale 1ns / 1ps
// back end: distance table memory, saturating accumulator and result register
// depends on rlen_pkg
module rlen_back #(
  parameter int MAX_POINTS = 128,
  parameter int DIST_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  output logic                           op_ready,
  input  rlen_pkg::rlen_op_t             op,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rlen_pkg::TOTAL_W-1:0]   route_length,
  output logic                           saturated
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int SUM_W  = rlen_pkg::TOTAL_W + 2;

  logic [DIST_WIDTH-1:0] table_mem [1 << ADDR_W];

  logic [ADDR_W-1:0]     leg_addr;
  logic [ADDR_W-1:0]     ret_addr;
  logic                  pop;

  // accumulate stage
  logic                  b_valid;
  logic                  b_first;
  logic                  b_last;
  logic                  b_leg_ok;
  logic                  b_ret_ok;
  logic [DIST_WIDTH-1:0] leg_q;
  logic [DIST_WIDTH-1:0] ret_q;
  logic                  b_fire;

  logic [rlen_pkg::TOTAL_W-1:0] total;
  logic [rlen_pkg::TOTAL_W-1:0] total_next;
  logic                         ovf;
  logic                         ovf_next;
  logic [SUM_W-1:0]             sum;
  logic [DIST_WIDTH-1:0]        leg;
  logic [DIST_WIDTH-1:0]        ret;
  logic [rlen_pkg::TOTAL_W-1:0] base;
  logic                         over;

  assign leg_addr = {op.leg_row[IDX_W-1:0], op.leg_col[IDX_W-1:0]};
  assign ret_addr = {op.ret_row[IDX_W-1:0], op.leg_col[IDX_W-1:0]};

  assign b_fire   = b_valid && (!b_last || !out_valid || out_ready);
  assign op_ready = !b_valid || b_fire;
  assign pop      = op_valid && op_ready;

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pop && !op.is_route && op.leg_ok) begin
      table_mem[leg_addr] <= op.wdata[DIST_WIDTH-1:0];
    end
    if (pop && op.is_route) begin
      leg_q <= table_mem[leg_addr];
      ret_q <= table_mem[ret_addr];
    end
  end

  // both legs of a closing stop fold into one add: the clamp is monotonic
  always_comb begin
    leg        = b_leg_ok ? leg_q : '0;
    ret        = (b_last && b_ret_ok) ? ret_q : '0;
    base       = b_first ? '0 : total;
    sum        = SUM_W'(base) + SUM_W'(leg) + SUM_W'(ret);
    over       = (sum[SUM_W-1:rlen_pkg::TOTAL_W] != '0);
    total_next = over ? '1 : sum[rlen_pkg::TOTAL_W-1:0];
    ovf_next   = (b_first ? 1'b0 : ovf) | over;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_first  <= op.first;
      b_last   <= op.last;
      b_leg_ok <= op.leg_ok;
      b_ret_ok <= op.ret_ok;
    end
    if (b_fire && b_last) begin
      route_length <= total_next;
      saturated    <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      total     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      priority if (pop) begin
        b_valid <= op.is_route;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        total <= total_next;
        ovf   <= ovf_next;
      end
      priority if (b_fire && b_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    b_fire && b_last |=> out_valid && (route_length == $past(total_next)))
    else $error("closing stop did not load the result register");

  a_ovf_clamped: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (&total))
    else $error("overflow flag set with an unclamped total");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_fire && b_last))
    else $error("result appeared without a closing stop");

endmodule

// ===== src/route_length_from_distance_table.sv =====
`timescale 1ns / 1ps
// top level of the route length block: stream ports, config register, front, queue, back
// depends on rlen_pkg, rlen_front, rlen_queue, rlen_back
//
//  channel  direction  handshake                     payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata fields, tlast = last_stop,
//                                                    tuser = command
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata = route_length,
//                                                    tuser = saturated
//  cfg      in         cfg_valid/cfg_ready           cfg_data = customer_count
//
// one input word per cycle unless m_axis stalls, writes and route stops alike; the
// figure is set by the distance table memory: one write, two read ports, once per word
// a closing stop's total reaches m_axis through the queue slot and the table read registers,
// then the accumulate stage loads it into the result register
// reset is synchronous and clears control state only; the table needs no clearing pass
// and holds whatever it held until written; customer_count comes back as 64
// a stall on m_axis holds the result register and a closing stop in the accumulate stage;
// the four-entry queue keeps taking words until it fills, then s_axis_tready drops
module route_length_from_distance_table #(
  parameter int MAX_POINTS = 128,
  parameter int DIST_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row[6:0], col[13:7], distance[37:14], customer[44:38], facility[47:45],
  // first_stop[48], zero fill[55:49]
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_stop
  input  logic        s_axis_tuser,   // command
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // route_length[31:0]
  output logic        m_axis_tuser,   // saturated
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data        // customer_count
);

  localparam logic [rlen_pkg::PT_W-1:0] CUSTOMER_COUNT_RST = rlen_pkg::PT_W'(64);

  logic [rlen_pkg::PT_W-1:0] customer_count;

  // front to queue
  logic               fq_valid;
  logic               fq_ready;
  rlen_pkg::rlen_op_t fq_op;
  // queue to back
  logic               qb_valid;
  logic               qb_ready;
  rlen_pkg::rlen_op_t qb_op;

  // config register; the user writes it only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      customer_count <= CUSTOMER_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      customer_count <= cfg_data;
    end
  end

  // classify incoming words and build table addresses
  rlen_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .customer_count (customer_count),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .command        (s_axis_tuser),
    .row            (s_axis_tdata[6:0]),
    .col            (s_axis_tdata[13:7]),
    .distance       (s_axis_tdata[37:14]),
    .customer       (s_axis_tdata[44:38]),
    .facility       (s_axis_tdata[47:45]),
    .first_stop     (s_axis_tdata[48]),
    .last_stop      (s_axis_tlast),
    .op_valid       (fq_valid),
    .op_ready       (fq_ready),
    .op             (fq_op)
  );

  // decouples the stream input from result back-pressure
  rlen_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_op     (fq_op),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_op    (qb_op)
  );

  // table writes, leg reads, saturating total and result register
  rlen_back #(
    .MAX_POINTS (MAX_POINTS),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (qb_valid),
    .op_ready     (qb_ready),
    .op           (qb_op),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .route_length (m_axis_tdata),
    .saturated    (m_axis_tuser)
  );

endmodule
